// ===== design/itl_pkg.sv =====
// Shared types, constants and helpers for the instruction cache tag lookup block.
package itl_pkg;

   // Field widths
   localparam int ADDR_W  = 56;
   localparam int TAG_W   = 44;
   localparam int TAG_LSB = 12;
   localparam int SET_LSB = 4;
   localparam int DELAY_W = 10;
   localparam int LFSR_W  = 8;

   // Associativity is fixed at four
   localparam int NUM_WAYS = 4;

   // Default geometry (number of sets must be a power of two)
   localparam int DEFAULT_NUM_SETS = 256;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_CACHE_DELAY  = 1'b0;
   localparam logic REG_MEMORY_DELAY = 1'b1;
   localparam logic [DELAY_W-1:0] CACHE_DELAY_RESET  = 10'd1;
   localparam logic [DELAY_W-1:0] MEMORY_DELAY_RESET = 10'd10;

   // Request and response payloads
   typedef struct packed {
      logic [ADDR_W-1:0] fetch_address;
      logic              cacheable;
   } req_type;

   typedef struct packed {
      logic               miss;
      logic [DELAY_W-1:0] delay;
   } rsp_type;

   // Write-back of one set: lane enables, new tag, new valid row
   typedef struct packed {
      logic                en;
      logic [NUM_WAYS-1:0] way_sel;
      logic [TAG_W-1:0]    tag;
      logic [NUM_WAYS-1:0] valid;
   } wr_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // XNOR LFSR, taps 7,3,2,1
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      lfsr_step = {s[LFSR_W-2:0], ~(s[7] ^ s[3] ^ s[2] ^ s[1])};
   endfunction

endpackage

// ===== design/icache_tag_lookup_delay.sv =====
// Top level of the instruction cache tag lookup with miss flag and delay report.
//
//  channel | direction | signals                             | transaction
//  req     | in        | req_valid/req_ready, req_payload    | fetch address, cacheable
//  rsp     | out       | rsp_valid/rsp_ready, rsp_payload    | miss, delay
//  apb     | in/out    | psel, penable, pwrite, paddr, ...   | delay registers at 0x0, 0x4
//
// Each transaction is read from the set store on acceptance (registered read),
// then compared and written back in the lookup state, which a held response can
// stall; one transaction is in flight. After reset a sweep clears the valid
// memory set by set; req_ready stays low meanwhile. A held response stalls the
// lookup cycle only.
module icache_tag_lookup_delay #(
   parameter int NUM_SETS = itl_pkg::DEFAULT_NUM_SETS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  itl_pkg::req_type                req_payload,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output itl_pkg::rsp_type                rsp_payload,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [itl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [itl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [itl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int SET_W = $clog2(NUM_SETS);
   localparam int NW    = itl_pkg::NUM_WAYS;

   itl_pkg::state_type state_ff, state_in;

   logic [itl_pkg::TAG_W-1:0]   tag_ff;
   logic [SET_W-1:0]            set_ff;
   logic                        cacheable_ff;
   logic [itl_pkg::LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [itl_pkg::DELAY_W-1:0] cache_delay_ff, memory_delay_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   itl_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   logic                        accept;
   logic                        csr_write;
   logic                        clear_busy;
   logic [NW-1:0][itl_pkg::TAG_W-1:0] rd_tags;
   logic [NW-1:0]               rd_valid;
   logic [NW-1:0]               way_hit;
   logic                        hit;
   logic [NW-1:0]               first_free;
   logic [NW-1:0]               victim;
   logic [itl_pkg::LFSR_W-1:0]  lfsr_nx;
   logic                        out_free;
   logic                        advance;
   itl_pkg::wr_type             wr;

   // Set store
   itl_set_store #(
      .NUM_SETS (NUM_SETS)
   ) u_set_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_index   (req_payload.fetch_address[itl_pkg::SET_LSB +: SET_W]),
      .rd_tags    (rd_tags),
      .rd_valid   (rd_valid),
      .wr         (wr),
      .wr_index   (set_ff),
      .clear_busy (clear_busy)
   );

   assign req_ready = (state_ff == itl_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Way compare and victim choice
   always_comb begin
      for (int w = 0; w < NW; w++) begin
         way_hit[w] = rd_valid[w] && (rd_tags[w] == tag_ff);
      end
      hit = |way_hit;

      first_free = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (!rd_valid[w]) begin
            first_free = '0;
            first_free[w] = 1'b1;
         end
      end

      lfsr_nx = itl_pkg::lfsr_step(lfsr_ff);
      if (|first_free) begin
         victim = first_free;
      end else begin
         victim = NW'(1) << lfsr_nx[1:0];
      end
   end

   // Sequencer, write-back and response load
   always_comb begin
      state_in       = state_ff;
      advance        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      lfsr_in        = lfsr_ff;
      wr.en          = 1'b0;
      wr.way_sel     = victim;
      wr.tag         = tag_ff;
      wr.valid       = rd_valid | victim;

      unique case (state_ff)
         itl_pkg::ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = itl_pkg::ST_IDLE;
            end
         end
         itl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = itl_pkg::ST_LOOKUP;
            end
         end
         itl_pkg::ST_LOOKUP: begin
            if (out_free) begin
               advance  = 1'b1;
               state_in = itl_pkg::ST_IDLE;
            end
         end
         default: state_in = itl_pkg::ST_IDLE;
      endcase

      if (advance) begin
         wr.en                = !hit;
         rsp_valid_in         = 1'b1;
         rsp_payload_in.miss  = !hit;
         rsp_payload_in.delay = (!cacheable_ff || !hit) ? memory_delay_ff : cache_delay_ff;
         if (!hit && !(|first_free)) begin
            lfsr_in = lfsr_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itl_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         lfsr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
      end
   end

   // Captured request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff       <= req_payload.fetch_address[itl_pkg::TAG_LSB +: itl_pkg::TAG_W];
         set_ff       <= req_payload.fetch_address[itl_pkg::SET_LSB +: SET_W];
         cacheable_ff <= req_payload.cacheable;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Delay registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_delay_ff  <= itl_pkg::CACHE_DELAY_RESET;
         memory_delay_ff <= itl_pkg::MEMORY_DELAY_RESET;
      end else if (csr_write) begin
         if (paddr[2] == itl_pkg::REG_CACHE_DELAY) begin
            cache_delay_ff <= pwdata[itl_pkg::DELAY_W-1:0];
         end else begin
            memory_delay_ff <= pwdata[itl_pkg::DELAY_W-1:0];
         end
      end
   end

   // Read-back
   always_comb begin
      prdata = '0;
      if (paddr[2] == itl_pkg::REG_MEMORY_DELAY) begin
         prdata[itl_pkg::DELAY_W-1:0] = memory_delay_ff;
      end else begin
         prdata[itl_pkg::DELAY_W-1:0] = cache_delay_ff;
      end
   end

endmodule

// ===== design/itl_set_store.sv =====
// Tag and valid memories of the set store, with the valid clearing sweep after reset.
module itl_set_store #(
   parameter int NUM_SETS = itl_pkg::DEFAULT_NUM_SETS,
   localparam int SET_W   = $clog2(NUM_SETS)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       rd_en,
   input  logic [SET_W-1:0]                           rd_index,
   output logic [itl_pkg::NUM_WAYS-1:0][itl_pkg::TAG_W-1:0] rd_tags,
   output logic [itl_pkg::NUM_WAYS-1:0]               rd_valid,
   input  itl_pkg::wr_type                            wr,
   input  logic [SET_W-1:0]                           wr_index,
   output logic                                       clear_busy
);

   logic [itl_pkg::NUM_WAYS-1:0][itl_pkg::TAG_W-1:0] tag_mem [NUM_SETS];
   logic [itl_pkg::NUM_WAYS-1:0]                     valid_mem [NUM_SETS];

   logic [itl_pkg::NUM_WAYS-1:0][itl_pkg::TAG_W-1:0] rd_tags_ff;
   logic [itl_pkg::NUM_WAYS-1:0]                     rd_valid_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [SET_W-1:0] clr_idx_ff, clr_idx_in;

   // Clearing sweep: one set per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == SET_W'(NUM_SETS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Tag memory: per-way lane write, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int w = 0; w < itl_pkg::NUM_WAYS; w++) begin
            if (wr.way_sel[w]) begin
               tag_mem[wr_index][w] <= wr.tag;
            end
         end
      end
      if (rd_en) begin
         rd_tags_ff <= tag_mem[rd_index];
      end
   end

   // Valid memory: sweep writes zeros, otherwise whole-row write-back
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         valid_mem[clr_idx_ff] <= '0;
      end else if (wr.en) begin
         valid_mem[wr_index] <= wr.valid;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_mem[rd_index];
      end
   end

   assign rd_tags    = rd_tags_ff;
   assign rd_valid   = rd_valid_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== design/itl_checker.sv =====
// Port-level checks of the tag lookup block, bound to the top level.
module itl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input itl_pkg::rsp_type rsp_payload
);

   // Sweep after reset holds off requests and responses
   a_reset_no_ready: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // One transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while lookup pending");

   // A fresh response traces back to an acceptance through the registered read and the lookup state
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

   // Held response stays stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped or changed while stalled");

endmodule

bind icache_tag_lookup_delay itl_checker u_itl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== tb/icache_tag_lookup_delay_checker.sv =====
// Checker for the tag lookup block: mirrors the tag store, predicts each response and compares.
module icache_tag_lookup_delay_checker
   import itl_pkg::*;
#(
   parameter int NUM_SETS = DEFAULT_NUM_SETS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    pending
);

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int ENTRIES = NUM_SETS * NUM_WAYS;
   localparam int MAX_LINES = 20;

   // Shadow copy of the tag store, valid bits, victim LFSR and delay registers
   logic [TAG_W-1:0]   shadow_tags  [ENTRIES];
   logic               shadow_valid [ENTRIES];
   logic [LFSR_W-1:0]  victim_state;
   logic [DELAY_W-1:0] hit_delay;
   logic [DELAY_W-1:0] miss_delay;

   // Responses predicted for accepted fetch transactions, oldest first
   rsp_type predicted_lookups [$];
   int      clear_idx;

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_LINES)
         $display("%0t: lookup mismatch: %s", $time, what);
      mismatches++;
   endtask

   // One lookup: compare four ways, allocate on a miss, pick the delay
   function automatic rsp_type predict_lookup(input req_type item);
      logic [TAG_W-1:0] tag;
      logic             hit;
      int               base;
      int               way;
      int               w;
      rsp_type          result;
      tag  = item.fetch_address[ADDR_W-1:TAG_LSB];
      base = int'(item.fetch_address[SET_LSB +: SET_W]) * NUM_WAYS;
      hit  = 1'b0;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (shadow_valid[base + w] && shadow_tags[base + w] == tag)
            hit = 1'b1;
      end
      if (!hit) begin
         // lowest invalid way first, else the LFSR names the victim
         way = NUM_WAYS;
         for (w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!shadow_valid[base + w])
               way = w;
         end
         if (way == NUM_WAYS) begin
            victim_state = {victim_state[LFSR_W-2:0],
                            ~(victim_state[7] ^ victim_state[3] ^
                              victim_state[2] ^ victim_state[1])};
            way = int'(victim_state[1:0]);
         end
         shadow_tags[base + way]  = tag;
         shadow_valid[base + way] = 1'b1;
      end
      result.miss  = !hit;
      result.delay = (!item.cacheable || !hit) ? miss_delay : hit_delay;
      return result;
   endfunction

   // Watch register writes and both channels at every rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (clear_idx = 0; clear_idx < ENTRIES; clear_idx++)
            shadow_valid[clear_idx] = 1'b0;
         victim_state = '0;
         hit_delay    = CACHE_DELAY_RESET;
         miss_delay   = MEMORY_DELAY_RESET;
         predicted_lookups.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_CACHE_DELAY, 2'b00})
               hit_delay = pwdata[DELAY_W-1:0];
            else if (paddr == {REG_MEMORY_DELAY, 2'b00})
               miss_delay = pwdata[DELAY_W-1:0];
         end
         // a response accepted here belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (predicted_lookups.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               if (rsp_payload.miss !== predicted_lookups[0].miss)
                  report_mismatch($sformatf("miss %b, expected %b",
                                            rsp_payload.miss, predicted_lookups[0].miss));
               if (rsp_payload.delay !== predicted_lookups[0].delay)
                  report_mismatch($sformatf("delay %0d, expected %0d",
                                            rsp_payload.delay, predicted_lookups[0].delay));
               void'(predicted_lookups.pop_front());
            end
         end
         if (req_valid && req_ready)
            predicted_lookups.push_back(predict_lookup(req_payload));
      end
      pending = predicted_lookups.size();
   end

endmodule

// ===== tb/icache_tag_lookup_delay_tb.sv =====
// Testbench top for the tag lookup block: drives fetches and register writes, prints the verdict.
module icache_tag_lookup_delay_tb;
   import itl_pkg::*;

   localparam int N_SETS      = DEFAULT_NUM_SETS;
   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int TAG_POOL    = 6;
   localparam int SET_POOL    = 3;
   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
   localparam logic [TAG_W-1:0] TAG_MAX = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    pending;

   int send_idle;
   int recv_stall;
   logic [TAG_W-1:0] tag_pool [TAG_POOL];
   logic [7:0]       set_pool [SET_POOL];

   icache_tag_lookup_delay #(.NUM_SETS(N_SETS)) u_dut (.*);

   icache_tag_lookup_delay_checker #(.NUM_SETS(N_SETS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side stalls at random
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall);

   // Present one fetch transaction and hold it until accepted
   task automatic send_fetch(input logic [TAG_W-1:0] tag, input logic [7:0] set_idx,
                             input logic [3:0] offs, input logic cacheable);
      req_type item;
      item.fetch_address = {tag, set_idx, offs};
      item.cacheable     = cacheable;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly a few tags over a few sets, so sets fill and victims get replaced
   task automatic send_random_fetch();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(99) < 80)
         send_fetch(tag_pool[$urandom_range(TAG_POOL - 1)],
                    set_pool[$urandom_range(SET_POOL - 1)], raw[3:0], raw[4]);
      else
         send_fetch(raw[55:12], raw[11:4], raw[3:0], raw[56]);
   endtask

   // Setup and access cycles; upper data bits are noise
   task automatic write_reg(input logic reg_idx, input logic [DELAY_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[DELAY_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Let every outstanding transaction come back, then a short pause
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [63:0] raw;
      logic [DELAY_W-1:0] hit_val;
      logic [DELAY_W-1:0] miss_val;
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      reset       <= 1'b1;
      send_idle   = 0;
      recv_stall  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset delays, empty sets, hits, fills, replacements
      send_fetch('0, 8'h00, 4'h0, 1'b0);       // uncacheable miss into empty set
      send_fetch('0, 8'h00, 4'h0, 1'b1);       // cacheable hit
      send_fetch('0, 8'h00, 4'hF, 1'b0);       // uncacheable hit
      send_fetch(TAG_MAX, 8'hFF, 4'hF, 1'b1);  // all-ones address
      send_fetch(TAG_MAX, 8'hFF, 4'hF, 1'b1);
      send_fetch(44'd1, 8'h00, 4'h0, 1'b1);    // fill remaining ways
      send_fetch(44'd2, 8'h00, 4'h0, 1'b1);
      send_fetch(44'd3, 8'h00, 4'h0, 1'b1);
      send_fetch(44'd1, 8'h00, 4'h8, 1'b1);
      send_fetch(44'd4, 8'h00, 4'h0, 1'b1);    // full set: LFSR victim
      send_fetch(44'd5, 8'h00, 4'h0, 1'b0);    // full set, uncacheable
      send_fetch(44'd6, 8'h00, 4'h0, 1'b1);
      send_fetch(44'd7, 8'h00, 4'h0, 1'b1);
      send_fetch(44'd8, 8'h00, 4'h0, 1'b1);
      send_fetch('0, 8'h00, 4'h0, 1'b1);
      send_fetch(44'd4, 8'h00, 4'h0, 1'b1);
      send_fetch(TAG_MAX, 8'h00, 4'h0, 1'b1);
      send_fetch(44'h123, 8'h05, 4'h3, 1'b0);  // uncacheable miss still allocates
      send_fetch(44'h123, 8'h05, 4'h3, 1'b1);
      send_fetch('0, 8'hFF, 4'h0, 1'b1);       // top set index
      send_fetch(TAG_MAX, 8'hFF, 4'h0, 1'b0);
      wait_drained();

      // Random phases: each sets its delays, and the idling pattern repeats every four phases
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 61; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 61; end
            default: begin send_idle = 36; recv_stall = 36; end
         endcase
         case (ph)
            0: begin hit_val = '0;        miss_val = DELAY_MAX; end
            1: begin hit_val = DELAY_MAX; miss_val = '0;        end
            2: begin hit_val = DELAY_MAX; miss_val = DELAY_MAX; end
            3: begin hit_val = '0;        miss_val = '0;        end
            default: begin
               hit_val  = DELAY_W'($urandom_range(DELAY_MAX));
               miss_val = DELAY_W'($urandom_range(DELAY_MAX));
            end
         endcase
         write_reg(REG_CACHE_DELAY, hit_val);
         write_reg(REG_MEMORY_DELAY, miss_val);
         for (int k = 0; k < TAG_POOL; k++) begin
            raw = {$urandom, $urandom};
            tag_pool[k] = ($urandom_range(1) != 0) ? raw[TAG_W-1:0] : {36'd0, raw[7:0]};
         end
         for (int k = 0; k < SET_POOL; k++)
            set_pool[k] = 8'($urandom_range(255));
         repeat (PHASE_ITEMS) send_random_fetch();
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
